// ===== hdl/quaternion_to_euler_angles_unit_defines.svh =====
// Assertion macros shared by the checker files of the quaternion to Euler unit.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef QUATERNION_TO_EULER_ANGLES_UNIT_DEFINES_SVH
`define QUATERNION_TO_EULER_ANGLES_UNIT_DEFINES_SVH

// Same-cycle implication
`define QTE_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("qte check failed");

// Next-cycle implication
`define QTE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("qte check failed");

`endif

// ===== hdl/qte_pkg.sv =====
// Shared constants, types and the arctangent table of the quaternion to Euler unit.
// No dependencies.
package qte_pkg;

  localparam int QTE_CORDIC_STEPS = 16;
  localparam int QTE_MAX_ITER     = 40;
  localparam int QTE_ROOT_STEPS   = 31;  // square root digits of a 61-bit radicand
  localparam int QTE_PW           = 34;  // Q.30 product width
  localparam int QTE_SW           = 32;  // saturated asin argument
  localparam int QTE_DW           = 40;  // CORDIC x/y datapath
  localparam int QTE_AW           = 34;  // angle accumulator, Q30 radians
  localparam int QTE_RW           = 62;  // square root remainder
  localparam int QTE_OW           = 16;  // angle result width
  localparam int QTE_PITCH_LIMIT  = 9001;
  localparam int QTE_ANGLE_LIMIT  = 18002;

  localparam logic signed [QTE_AW-1:0] QTE_HALF_PI = 34'sd1686629713;
  localparam logic signed [15:0]       QTE_SCALE   = 16'sd5730;

  // Sideband that travels with each pipeline slot
  typedef struct packed {
    logic valid;
    logic present;
  } qte_ctrl_t;

  // round(atan(2^-i) * 2^30)
  function automatic logic signed [QTE_AW-1:0] atan_entry(input int unsigned i);
    logic signed [QTE_AW-1:0] r;
    r = '0;
    case (i)
      0:  r = 34'sd843314857;
      1:  r = 34'sd497837829;
      2:  r = 34'sd263043837;
      3:  r = 34'sd133525159;
      4:  r = 34'sd67021687;
      5:  r = 34'sd33543516;
      6:  r = 34'sd16775851;
      7:  r = 34'sd8388437;
      8:  r = 34'sd4194283;
      9:  r = 34'sd2097149;
      10: r = 34'sd1048576;
      default: begin
        if (i <= 30) r = QTE_AW'(1) <<< (30 - i);
      end
    endcase
    return r;
  endfunction

endpackage

// ===== hdl/qte_products.sv =====
// Component products and the three atan2 operand pairs (two register stages).
// Depends on qte_pkg.
module qte_products (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  qte_pkg::qte_ctrl_t                ctrl_i,
  input  logic signed [31:0]                quat_w_i,
  input  logic signed [31:0]                quat_x_i,
  input  logic signed [31:0]                quat_y_i,
  input  logic signed [31:0]                quat_z_i,
  output qte_pkg::qte_ctrl_t                ctrl_o,
  output logic signed [qte_pkg::QTE_SW-1:0] sin_arg_o,
  output logic signed [qte_pkg::QTE_DW-1:0] roll_y_o,
  output logic signed [qte_pkg::QTE_DW-1:0] roll_x_o,
  output logic signed [qte_pkg::QTE_DW-1:0] yaw_y_o,
  output logic signed [qte_pkg::QTE_DW-1:0] yaw_x_o
);
  import qte_pkg::*;

  // Exact product, floor shift by 30
  function automatic logic signed [QTE_PW-1:0] mulq(input logic signed [31:0] a,
                                                    input logic signed [31:0] b);
    logic signed [63:0] p;
    p = a * b;
    return p[63:30];
  endfunction

  qte_ctrl_t ctrl1_q, ctrl2_q;
  logic signed [QTE_PW-1:0] wy_q, xz_q, yz_q, wx_q, xx_q, yy_q, xy_q, wz_q, ww_q, zz_q;
  logic signed [35:0] s_w, ry_w, rx_w, yy_w, yx_w;
  logic signed [QTE_SW-1:0] s_sat;
  logic signed [QTE_SW-1:0] sin_arg_q;
  logic signed [QTE_DW-1:0] roll_y_q, roll_x_q, yaw_y_q, yaw_x_q;

  // Stage 1: ten products
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl1_q <= '0;
      ctrl2_q <= '0;
    end else if (en_i) begin
      ctrl1_q <= ctrl_i;
      ctrl2_q <= ctrl1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      wy_q <= mulq(quat_w_i, quat_y_i);
      xz_q <= mulq(quat_x_i, quat_z_i);
      yz_q <= mulq(quat_y_i, quat_z_i);
      wx_q <= mulq(quat_w_i, quat_x_i);
      xx_q <= mulq(quat_x_i, quat_x_i);
      yy_q <= mulq(quat_y_i, quat_y_i);
      xy_q <= mulq(quat_x_i, quat_y_i);
      wz_q <= mulq(quat_w_i, quat_z_i);
      ww_q <= mulq(quat_w_i, quat_w_i);
      zz_q <= mulq(quat_z_i, quat_z_i);
    end
  end

  // Stage 2: sums, doubling, asin argument saturation
  always_comb begin
    s_w  = (36'(wy_q) - 36'(xz_q)) <<< 1;
    ry_w = (36'(yz_q) + 36'(wx_q)) <<< 1;
    rx_w = 36'sd1073741824 - ((36'(xx_q) + 36'(yy_q)) <<< 1);
    yy_w = (36'(xy_q) + 36'(wz_q)) <<< 1;
    yx_w = 36'(ww_q) + 36'(xx_q) - 36'(yy_q) - 36'(zz_q);
    if (s_w > 36'sd1073741824) begin
      s_sat = 32'sd1073741824;
    end else if (s_w < -36'sd1073741824) begin
      s_sat = -32'sd1073741824;
    end else begin
      s_sat = s_w[QTE_SW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sin_arg_q <= s_sat;
      roll_y_q  <= QTE_DW'(ry_w);
      roll_x_q  <= QTE_DW'(rx_w);
      yaw_y_q   <= QTE_DW'(yy_w);
      yaw_x_q   <= QTE_DW'(yx_w);
    end
  end

  assign ctrl_o    = ctrl2_q;
  assign sin_arg_o = sin_arg_q;
  assign roll_y_o  = roll_y_q;
  assign roll_x_o  = roll_x_q;
  assign yaw_y_o   = yaw_y_q;
  assign yaw_x_o   = yaw_x_q;

endmodule

// ===== hdl/qte_cos_root.sv =====
// Pitch cosine: c = floor(sqrt((1 - s)(1 + s))), one multiply stage then one root
// digit per stage. Depends on qte_pkg.
module qte_cos_root (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  qte_pkg::qte_ctrl_t                ctrl_i,
  input  logic signed [qte_pkg::QTE_SW-1:0] sin_arg_i,
  output qte_pkg::qte_ctrl_t                ctrl_o,
  output logic signed [qte_pkg::QTE_DW-1:0] sin_o,
  output logic signed [qte_pkg::QTE_DW-1:0] cos_o
);
  import qte_pkg::*;

  localparam int N = QTE_ROOT_STEPS;

  qte_ctrl_t                ctrl_q [N+1];
  logic signed [QTE_SW-1:0] s_q    [N+1];
  logic [QTE_RW-1:0]        rem_q  [N+1];
  logic [QTE_RW-1:0]        root_q [N+1];
  logic [31:0]              a_lo, a_hi;
  logic [63:0]              m_full;

  // Radicand
  always_comb begin
    a_lo   = 32'(33'sd1073741824 - 33'(sin_arg_i));
    a_hi   = 32'(33'sd1073741824 + 33'(sin_arg_i));
    m_full = 64'(a_lo) * 64'(a_hi);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q[0] <= '0;
    end else if (en_i) begin
      ctrl_q[0] <= ctrl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s_q[0]    <= sin_arg_i;
      rem_q[0]  <= m_full[QTE_RW-1:0];
      root_q[0] <= '0;
    end
  end

  // Restoring square root, one result bit per stage
  for (genvar j = 0; j < N; j++) begin : g_root
    localparam logic [QTE_RW-1:0] BIT = QTE_RW'(1) << (2 * (N - 1 - j));
    logic [QTE_RW-1:0] trial, rem_d, root_d;

    always_comb begin
      trial = root_q[j] + BIT;
      if (rem_q[j] >= trial) begin
        rem_d  = rem_q[j] - trial;
        root_d = (root_q[j] >> 1) + BIT;
      end else begin
        rem_d  = rem_q[j];
        root_d = root_q[j] >> 1;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        ctrl_q[j+1] <= '0;
      end else if (en_i) begin
        ctrl_q[j+1] <= ctrl_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        s_q[j+1]    <= s_q[j];
        rem_q[j+1]  <= rem_d;
        root_q[j+1] <= root_d;
      end
    end
  end

  assign ctrl_o = ctrl_q[N];
  assign sin_o  = QTE_DW'(s_q[N]);
  assign cos_o  = QTE_DW'(root_q[N][31:0]);

endmodule

// ===== hdl/qte_delay.sv =====
// Register delay line that keeps roll and yaw operands aligned with the pitch path.
// Depends on qte_pkg.
module qte_delay #(
  parameter int DEPTH  = 32,
  parameter int DATA_W = 160
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  qte_pkg::qte_ctrl_t ctrl_i,
  input  logic [DATA_W-1:0]  data_i,
  output qte_pkg::qte_ctrl_t ctrl_o,
  output logic [DATA_W-1:0]  data_o
);
  import qte_pkg::*;

  qte_ctrl_t         ctrl_q [DEPTH];
  logic [DATA_W-1:0] data_q [DEPTH];

  for (genvar k = 0; k < DEPTH; k++) begin : g_tap
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        ctrl_q[k] <= '0;
      end else if (en_i) begin
        ctrl_q[k] <= (k == 0) ? ctrl_i : ctrl_q[(k == 0) ? 0 : k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        data_q[k] <= (k == 0) ? data_i : data_q[(k == 0) ? 0 : k-1];
      end
    end
  end

  assign ctrl_o = ctrl_q[DEPTH-1];
  assign data_o = data_q[DEPTH-1];

endmodule

// ===== hdl/qte_cordic.sv =====
// Pipelined vectoring CORDIC atan2 with quadrant pre-rotation and scaling to
// hundredths of a degree. Depends on qte_pkg.
module qte_cordic #(
  parameter int STEPS = qte_pkg::QTE_CORDIC_STEPS,
  parameter int LIMIT = qte_pkg::QTE_ANGLE_LIMIT
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  qte_pkg::qte_ctrl_t                ctrl_i,
  input  logic signed [qte_pkg::QTE_DW-1:0] y_i,
  input  logic signed [qte_pkg::QTE_DW-1:0] x_i,
  output qte_pkg::qte_ctrl_t                ctrl_o,
  output logic signed [qte_pkg::QTE_OW-1:0] angle_o
);
  import qte_pkg::*;

  localparam int ITER = (STEPS > QTE_MAX_ITER) ? QTE_MAX_ITER : STEPS;
  localparam logic signed [17:0] LIM = 18'(LIMIT);

  qte_ctrl_t                ctrl_q [ITER+1];
  logic                     zero_q [ITER+1];
  logic signed [QTE_DW-1:0] x_q    [ITER+1];
  logic signed [QTE_DW-1:0] y_q    [ITER+1];
  logic signed [QTE_AW-1:0] acc_q  [ITER+1];

  logic signed [QTE_DW-1:0] x0_d, y0_d;
  logic signed [QTE_AW-1:0] acc0_d;

  qte_ctrl_t          ctrl_m_q, ctrl_o_q;
  logic               zero_m_q;
  logic signed [47:0] scaled_q;
  logic signed [17:0] deg_w;
  logic signed [QTE_OW-1:0] angle_d, angle_q;

  // Pre-rotation into the right half plane
  always_comb begin
    x0_d   = x_i;
    y0_d   = y_i;
    acc0_d = '0;
    if (x_i < 0) begin
      if (y_i >= 0) begin
        x0_d   = y_i;
        y0_d   = -x_i;
        acc0_d = QTE_HALF_PI;
      end else begin
        x0_d   = -y_i;
        y0_d   = x_i;
        acc0_d = -QTE_HALF_PI;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q[0] <= '0;
    end else if (en_i) begin
      ctrl_q[0] <= ctrl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      zero_q[0] <= (x_i == '0) && (y_i == '0);
      x_q[0]    <= x0_d;
      y_q[0]    <= y0_d;
      acc_q[0]  <= acc0_d;
    end
  end

  // One micro-rotation per stage
  for (genvar i = 0; i < ITER; i++) begin : g_iter
    logic signed [QTE_DW-1:0] xs, ys;

    always_comb begin
      xs = x_q[i] >>> i;
      ys = y_q[i] >>> i;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        ctrl_q[i+1] <= '0;
      end else if (en_i) begin
        ctrl_q[i+1] <= ctrl_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        zero_q[i+1] <= zero_q[i];
        if (y_q[i] >= 0) begin
          x_q[i+1]   <= x_q[i] + ys;
          y_q[i+1]   <= y_q[i] - xs;
          acc_q[i+1] <= acc_q[i] + atan_entry(i);
        end else begin
          x_q[i+1]   <= x_q[i] - ys;
          y_q[i+1]   <= y_q[i] + xs;
          acc_q[i+1] <= acc_q[i] - atan_entry(i);
        end
      end
    end
  end

  // Scale to hundredths of a degree, then round and clamp
  always_comb begin
    deg_w = scaled_q[47:30];
    if (zero_m_q) begin
      angle_d = '0;
    end else if (deg_w > LIM) begin
      angle_d = QTE_OW'(LIM);
    end else if (deg_w < -LIM) begin
      angle_d = QTE_OW'(-LIM);
    end else begin
      angle_d = deg_w[QTE_OW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_m_q <= '0;
      ctrl_o_q <= '0;
    end else if (en_i) begin
      ctrl_m_q <= ctrl_q[ITER];
      ctrl_o_q <= ctrl_m_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      zero_m_q <= zero_q[ITER];
      scaled_q <= 48'(acc_q[ITER]) * 48'(QTE_SCALE) + 48'sd536870912;
      angle_q  <= angle_d;
    end
  end

  assign ctrl_o  = ctrl_o_q;
  assign angle_o = angle_q;

endmodule

// ===== hdl/quaternion_to_euler_angles_unit.sv =====
// Quaternion to Euler angles. Takes one Q2.30 quaternion per clock and returns pitch,
// roll and yaw in hundredths of a degree, through two stages of component products
// and sums, one multiply and 31 square-root digit stages for the pitch cosine, then a
// pre-rotation stage, CORDIC_STEPS micro-rotation stages and two scaling stages per
// angle. Roll and yaw wait in a delay line while the pitch cosine is formed. Throughput
// is one transaction per cycle; the whole pipeline holds while a result is not taken.
// Depends on qte_pkg and all qte_* modules.
module quaternion_to_euler_angles_unit #(
  parameter int CORDIC_STEPS = qte_pkg::QTE_CORDIC_STEPS
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [31:0] quat_w_i,
  input  logic signed [31:0] quat_x_i,
  input  logic signed [31:0] quat_y_i,
  input  logic signed [31:0] quat_z_i,
  input  logic               quat_present_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [14:0] pitch_angle_o,
  output logic signed [15:0] roll_angle_o,
  output logic signed [15:0] yaw_angle_o,
  output logic               status_code_o
);
  import qte_pkg::*;

  localparam int DLY = QTE_ROOT_STEPS + 1;

  logic en;
  qte_ctrl_t ctrl_in, ctrl_prod, ctrl_root, ctrl_dly, ctrl_pitch, ctrl_roll, ctrl_yaw;
  logic signed [QTE_SW-1:0] sin_arg;
  logic signed [QTE_DW-1:0] roll_y, roll_x, yaw_y, yaw_x;
  logic signed [QTE_DW-1:0] sin_v, cos_v;
  logic [4*QTE_DW-1:0]      dly_out;
  logic signed [QTE_OW-1:0] pitch, roll, yaw;

  // Global advance: the output slot is empty or being taken
  assign en         = !ctrl_roll.valid || out_ready_i;
  assign in_ready_o = en;
  assign ctrl_in    = '{valid: in_valid_i, present: quat_present_i};

  qte_products u_products (
    .clk_i, .rst_ni, .en_i(en), .ctrl_i(ctrl_in),
    .quat_w_i, .quat_x_i, .quat_y_i, .quat_z_i,
    .ctrl_o(ctrl_prod), .sin_arg_o(sin_arg),
    .roll_y_o(roll_y), .roll_x_o(roll_x), .yaw_y_o(yaw_y), .yaw_x_o(yaw_x)
  );

  qte_cos_root u_cos_root (
    .clk_i, .rst_ni, .en_i(en), .ctrl_i(ctrl_prod), .sin_arg_i(sin_arg),
    .ctrl_o(ctrl_root), .sin_o(sin_v), .cos_o(cos_v)
  );

  qte_delay #(.DEPTH(DLY), .DATA_W(4*QTE_DW)) u_delay (
    .clk_i, .rst_ni, .en_i(en), .ctrl_i(ctrl_prod),
    .data_i({roll_y, roll_x, yaw_y, yaw_x}),
    .ctrl_o(ctrl_dly), .data_o(dly_out)
  );

  qte_cordic #(.STEPS(CORDIC_STEPS), .LIMIT(QTE_PITCH_LIMIT)) u_pitch (
    .clk_i, .rst_ni, .en_i(en), .ctrl_i(ctrl_root),
    .y_i(sin_v), .x_i(cos_v), .ctrl_o(ctrl_pitch), .angle_o(pitch)
  );

  qte_cordic #(.STEPS(CORDIC_STEPS), .LIMIT(QTE_ANGLE_LIMIT)) u_roll (
    .clk_i, .rst_ni, .en_i(en), .ctrl_i(ctrl_dly),
    .y_i(dly_out[4*QTE_DW-1:3*QTE_DW]), .x_i(dly_out[3*QTE_DW-1:2*QTE_DW]),
    .ctrl_o(ctrl_roll), .angle_o(roll)
  );

  qte_cordic #(.STEPS(CORDIC_STEPS), .LIMIT(QTE_ANGLE_LIMIT)) u_yaw (
    .clk_i, .rst_ni, .en_i(en), .ctrl_i(ctrl_dly),
    .y_i(dly_out[2*QTE_DW-1:QTE_DW]), .x_i(dly_out[QTE_DW-1:0]),
    .ctrl_o(ctrl_yaw), .angle_o(yaw)
  );

  // Result, zeroed when no quaternion came with the transaction
  assign out_valid_o   = ctrl_roll.valid && ctrl_pitch.valid && ctrl_yaw.valid;
  assign status_code_o = !ctrl_roll.present;
  assign pitch_angle_o = ctrl_roll.present ? pitch[14:0] : '0;
  assign roll_angle_o  = ctrl_roll.present ? roll : '0;
  assign yaw_angle_o   = ctrl_roll.present ? yaw : '0;

endmodule

// ===== hdl/qte_checker.sv =====
// Port-level checks for the quaternion to Euler unit, bound to the top level.
// Depends on quaternion_to_euler_angles_unit_defines.svh.
`include "quaternion_to_euler_angles_unit_defines.svh"

module qte_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic signed [31:0] quat_w_i,
  input logic signed [31:0] quat_x_i,
  input logic signed [31:0] quat_y_i,
  input logic signed [31:0] quat_z_i,
  input logic               quat_present_i,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic signed [14:0] pitch_angle_o,
  input logic signed [15:0] roll_angle_o,
  input logic signed [15:0] yaw_angle_o,
  input logic               status_code_o
);

  // A stalled result stays offered
  `QTE_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o)

  // Absent quaternion gives all-zero angles
  `QTE_ASSERT_NOW(a_absent_zero, out_valid_o && status_code_o, pitch_angle_o == '0 && roll_angle_o == '0 && yaw_angle_o == '0)

  // Pitch stays within a quarter turn
  `QTE_ASSERT_NOW(a_pitch_range, out_valid_o, pitch_angle_o >= -15'sd9001 && pitch_angle_o <= 15'sd9001)

  // Roll and yaw stay within a half turn
  `QTE_ASSERT_NOW(a_rot_range, out_valid_o, roll_angle_o >= -16'sd18002 && roll_angle_o <= 16'sd18002 && yaw_angle_o >= -16'sd18002 && yaw_angle_o <= 16'sd18002)

endmodule

bind quaternion_to_euler_angles_unit qte_checker u_qte_checker (.*);

// ===== test/tb_quaternion_to_euler_angles_unit.sv =====
// Testbench for quaternion_to_euler_angles_unit: directed table plus random quaternions,
// checked against a local fixed-point predictor of pitch, roll and yaw.
// Depends on qte_pkg and the unit's RTL.
`timescale 1ns / 100ps

module tb_quaternion_to_euler_angles_unit;

  localparam int STEPS      = 16;
  localparam int LATENCY    = STEPS + 37;
  localparam int N_RANDOM   = 830;
  localparam longint ONE    = 64'sd1073741824;
  localparam longint HALF_PI = 64'sd1686629713;

  typedef struct {
    logic signed [14:0] pitch;
    logic signed [15:0] roll;
    logic signed [15:0] yaw;
    logic               status;
  } angles_t;

  typedef struct {
    logic signed [31:0] w, x, y, z;
    logic               present;
    logic               typed;   // expected result given in the row
    angles_t            exp;
  } quat_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic signed [31:0] quat_w_i = '0, quat_x_i = '0, quat_y_i = '0, quat_z_i = '0;
  logic quat_present_i = 1'b0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [14:0] pitch_angle_o;
  logic signed [15:0] roll_angle_o, yaw_angle_o;
  logic status_code_o;

  quaternion_to_euler_angles_unit #(.CORDIC_STEPS(STEPS)) uut (.*);

  always #2 clk_i = ~clk_i;

  angles_t    angles_pending[$];
  int         errors = 0;
  int         n_results = 0;
  int         n_sent = 0;
  int         send_idle_pct = 24;
  int         recv_idle_pct = 60;
  int         hold_cycles = 0;

  // Floor shift of a signed value
  function automatic longint floor_shr(longint v, int k);
    return v >>> k;
  endfunction

  function automatic longint prod_q30(longint a, longint b);
    return floor_shr(a * b, 30);
  endfunction

  function automatic longint root_floor(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else r >>= 1;
      b >>= 2;
    end
    return longint'(r);
  endfunction

  function automatic longint arctan_step(int i);
    longint head[11] = '{843314857, 497837829, 263043837, 133525159, 67021687,
                         33543516, 16775851, 8388437, 4194283, 2097149, 1048576};
    if (i < 11) return head[i];
    if (i <= 30) return 64'sd1 << (30 - i);
    return 0;
  endfunction

  // Vectoring CORDIC arctangent, Q30 radians
  function automatic longint vector_angle(longint y, longint x);
    longint acc, t, xs, ys;
    int n;
    acc = 0;
    n = (STEPS > 40) ? 40 : STEPS;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      if (y >= 0) begin
        t = y; y = -x; x = t; acc = HALF_PI;
      end else begin
        t = -y; y = x; x = t; acc = -HALF_PI;
      end
    end
    for (int i = 0; i < n; i++) begin
      xs = floor_shr(x, i);
      ys = floor_shr(y, i);
      if (y >= 0) begin
        x += ys; y -= xs; acc += arctan_step(i);
      end else begin
        x -= ys; y += xs; acc -= arctan_step(i);
      end
    end
    return acc;
  endfunction

  function automatic longint to_centideg(longint acc, longint lim);
    longint v;
    v = floor_shr(acc * 5730 + (64'sd1 << 29), 30);
    if (v > lim) v = lim;
    if (v < -lim) v = -lim;
    return v;
  endfunction

  function automatic angles_t euler_of(logic signed [31:0] qw, logic signed [31:0] qx,
                                       logic signed [31:0] qy, logic signed [31:0] qz,
                                       logic present);
    angles_t r;
    longint w, x, y, z, s, c;
    r = '{pitch: '0, roll: '0, yaw: '0, status: 1'b1};
    if (!present) return r;
    w = qw; x = qx; y = qy; z = qz;
    s = 2 * (prod_q30(w, y) - prod_q30(x, z));
    if (s > ONE) s = ONE;
    if (s < -ONE) s = -ONE;
    c = root_floor(longint'(longint'(ONE - s) * longint'(ONE + s)));
    r.pitch = 15'(to_centideg(vector_angle(s, c), 9001));
    r.roll = 16'(to_centideg(vector_angle(2 * (prod_q30(y, z) + prod_q30(w, x)),
                 ONE - 2 * (prod_q30(x, x) + prod_q30(y, y))), 18002));
    r.yaw = 16'(to_centideg(vector_angle(2 * (prod_q30(x, y) + prod_q30(w, z)),
                prod_q30(w, w) + prod_q30(x, x) - prod_q30(y, y) - prod_q30(z, z)), 18002));
    r.status = 1'b0;
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s at result %0d: got %0d, expected %0d", what, n_results, got, want);
    errors++;
  endtask

  // Directed rows; typed expectations only for absent items and obvious extremes
  quat_row_t directed[$];
  function automatic quat_row_t row(logic signed [31:0] w, x, y, z, logic p, logic t = 0,
                                    angles_t e = '{0, 0, 0, 0});
    quat_row_t r;
    r.w = w; r.x = x; r.y = y; r.z = z; r.present = p; r.typed = t; r.exp = e;
    return r;
  endfunction

  initial begin
    directed.push_back(row(32'sd1073741824, 0, 0, 0, 1, 1, '{0, 0, 0, 0}));  // identity
    directed.push_back(row(0, 0, 0, 0, 1, 1, '{0, 0, 0, 0}));                // all zero
    directed.push_back(row(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 0, 1,
                           '{0, 0, 0, 1}));                                  // absent
    directed.push_back(row(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 0, 1,
                           '{0, 0, 0, 1}));
    directed.push_back(row(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 1));
    directed.push_back(row(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 1));
    directed.push_back(row(32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000, 1));
    directed.push_back(row(32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 1));
    // asin saturation both ways
    directed.push_back(row(32'sd1073741824, 0, 32'sd1073741824, 0, 1));
    directed.push_back(row(32'sd1073741824, 0, -32'sd1073741824, 0, 1));
    directed.push_back(row(32'sd759250125, 0, 32'sd759250125, 0, 1));        // gimbal lock
    directed.push_back(row(0, 32'sd1073741824, 0, 0, 1));                    // roll 180
    directed.push_back(row(0, 0, 0, 32'sd1073741824, 1));                    // yaw 180
    directed.push_back(row(32'sd759250125, 32'sd759250125, 0, 0, 1));
    directed.push_back(row(32'sd759250125, -32'sd759250125, 0, 0, 1));
    directed.push_back(row(32'sd759250125, 0, 0, -32'sd759250125, 1));
    directed.push_back(row(0, 0, 32'sd1073741824, 32'sd1073741824, 1));      // unnormalized
    directed.push_back(row(-1, -1, -1, -1, 1));
    directed.push_back(row(1, 1, 1, 1, 1));
    directed.push_back(row(32'sd536870912, 32'sd536870912, 32'sd536870912, 32'sd536870912, 1));
  end

  // Feed one transaction; valid drops only while the sender idles
  task automatic offer_quat(quat_row_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    quat_w_i <= r.w; quat_x_i <= r.x; quat_y_i <= r.y; quat_z_i <= r.z;
    quat_present_i <= r.present;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    angles_pending.push_back(r.typed ? r.exp : euler_of(r.w, r.x, r.y, r.z, r.present));
    n_sent++;
    @(negedge clk_i);
  endtask

  function automatic logic signed [31:0] rand_comp(int mode);
    case (mode)
      0: return $urandom;
      1: return $signed(32'($urandom_range(0, 32'h8000_0000)) - 32'sd1073741824);
      default: return $signed(32'($urandom_range(0, 2000)) - 32'sd1000);
    endcase
  endfunction

  // Stimulus
  initial begin
    quat_row_t r;
    int mode;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    foreach (directed[i]) offer_quat(directed[i]);
    for (int k = 0; k < N_RANDOM; k++) begin
      if (k == N_RANDOM / 3) begin
        send_idle_pct = 60; recv_idle_pct = 24;
      end
      if (k == 2 * N_RANDOM / 3) begin
        send_idle_pct = 0; recv_idle_pct = 0;
        hold_cycles = 200;   // receiver stalls long; pipeline fills
      end
      mode = ($urandom_range(9) < 7) ? 1 : $urandom_range(2);
      r = row(rand_comp(mode), rand_comp(mode), rand_comp(mode), rand_comp(mode),
              $urandom_range(9) != 0);
      offer_quat(r);
    end
    in_valid_i <= 1'b0;
    while (angles_pending.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 10) @(posedge clk_i);
    $display("sent %0d quaternions (directed extremes, absent items, random), %0d results checked",
             n_sent, n_results);
    $display("idle mixes: sender-heavy, receiver-heavy, none, plus one long output stall");
    if (errors == 0) $display("tb_quaternion_to_euler_angles_unit: done, clean");
    else $display("tb_quaternion_to_euler_angles_unit: done, errors");
    $finish;
  end

  // Receiver ready, with random idling and one long hold-off
  always @(negedge clk_i) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ready_i <= 1'b0;
    end else out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Compare each result transaction with the oldest expectation
  always @(posedge clk_i) begin
    angles_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (angles_pending.size() == 0) begin
        $display("unexpected result at %0d", n_results);
        errors++;
      end else begin
        e = angles_pending.pop_front();
        if (pitch_angle_o !== e.pitch) report_mismatch("pitch", pitch_angle_o, e.pitch);
        if (roll_angle_o !== e.roll) report_mismatch("roll", roll_angle_o, e.roll);
        if (yaw_angle_o !== e.yaw) report_mismatch("yaw", yaw_angle_o, e.yaw);
        if (status_code_o !== e.status) report_mismatch("status", status_code_o, e.status);
      end
      n_results++;
    end
  end

  // Watchdog
  initial begin
    #2000000;
    $display("tb_quaternion_to_euler_angles_unit: done, errors");
    $finish;
  end

endmodule
